// File: hw/rtl/tgqvt_pkg.sv
// Shared types and constants for the two-group quorum vote tally.
package tgqvt_pkg;

  localparam int MAX_MEMBERS = 16;
  localparam int IDX_W       = $clog2(MAX_MEMBERS);
  localparam int LIM_W       = $clog2(MAX_MEMBERS + 1);
  localparam int SIZE_W      = 5;
  localparam int CNT_W       = 8;
  localparam int ID_W        = 64;
  localparam int SLOT_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ACCEPT = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SIZE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ID_W-1:0]   node_id;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic in_first_group;
    logic round_accepted;
    logic round_rejected;
    logic round_complete;
  } out_item_t;

endpackage

// File: hw/rtl/two_group_quorum_vote_tally_core.sv
// Two-group quorum vote tally: ID slots, one shared ID comparator, counters, status.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word per item: load an
//   ID into a slot, cast an accept or reject vote, or clear the tally.
//   Output channel (out_valid/out_ready/out_data) returns one status word per
//   item: group-one hit flag plus accepted, rejected and complete flags.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the group
//   sizes, always ready; written only while the block is idle (a user duty).
// Timing:
//   A vote walks the stored IDs through one 64-bit comparator, one slot per
//   cycle over min(first_group_size, 16) slots. Loads and clears skip the
//   walk. One item is in flight at a time; in_ready rises in the same cycle
//   as out_valid.
// Reset: counters, group sizes, sequencer and out_valid clear; ID slots keep
//   whatever they held and must be loaded before they are matched.
// Stall: a result waits in the output register; the block takes the next
//   word meanwhile but holds that result until the register is free.
module two_group_quorum_vote_tally_core
  import tgqvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;

  logic [SIZE_W-1:0] first_size;
  logic [SIZE_W-1:0] second_size;

  logic [ID_W-1:0]   member_ids [MAX_MEMBERS];
  logic [ID_W-1:0]   rd_data;
  logic              cmp_en;

  logic [1:0]        op;
  logic [ID_W-1:0]   id;
  logic [LIM_W-1:0]  idx;
  logic [LIM_W-1:0]  lim;
  logic              hit;

  logic [CNT_W-1:0]  accepts_first;
  logic [CNT_W-1:0]  accepts_second;
  logic [CNT_W-1:0]  rejects_first;
  logic [CNT_W-1:0]  rejects_second;

  logic              in_fire;
  logic              out_free;
  out_item_t         status;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign lim = (32'(first_size) > MAX_MEMBERS) ? LIM_W'(MAX_MEMBERS) : LIM_W'(first_size);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_size  <= '0;
      second_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIRST_SIZE) begin
        first_size <= cfg_data;
      end else if (cfg_index == REG_SECOND_SIZE) begin
        second_size <= cfg_data;
      end
    end
  end

  // ID slot memory: write on a load word, registered read at the walk index
  always_ff @(posedge clk) begin
    if (in_fire && in_data.opcode == OP_LOAD && 32'(in_data.slot) < MAX_MEMBERS) begin
      member_ids[in_data.slot[IDX_W-1:0]] <= in_data.node_id;
    end
    rd_data <= member_ids[idx[IDX_W-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (in_data.opcode == OP_ACCEPT || in_data.opcode == OP_REJECT)
                       ? ST_SEARCH : ST_UPDATE;
        end
      end
      ST_SEARCH: begin
        if (idx >= lim) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer, walk index and shared comparator
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cmp_en <= 1'b0;
      idx    <= '0;
      hit    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        hit <= 1'b0;
      end else if (cmp_en && rd_data == id) begin
        // compare the slot read on the previous cycle
        hit <= 1'b1;
      end
      if (in_fire) begin
        idx    <= '0;
        cmp_en <= 1'b0;
      end else if (state == ST_SEARCH && idx < lim) begin
        idx    <= idx + LIM_W'(1);
        cmp_en <= 1'b1;
      end else begin
        cmp_en <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op <= in_data.opcode;
      id <= in_data.node_id;
    end
  end

  // Tally counters
  always_ff @(posedge clk) begin
    if (rst) begin
      accepts_first  <= '0;
      accepts_second <= '0;
      rejects_first  <= '0;
      rejects_second <= '0;
    end else if (state == ST_UPDATE) begin
      case (op)
        OP_ACCEPT: begin
          if (hit) accepts_first <= sat_inc(accepts_first);
          else     accepts_second <= sat_inc(accepts_second);
        end
        OP_REJECT: begin
          if (hit) rejects_first <= sat_inc(rejects_first);
          else     rejects_second <= sat_inc(rejects_second);
        end
        OP_CLEAR: begin
          accepts_first  <= '0;
          accepts_second <= '0;
          rejects_first  <= '0;
          rejects_second <= '0;
        end
        default: ;
      endcase
    end
  end

  // Round status from the updated counters
  always_comb begin
    status.in_first_group = hit;
    status.round_accepted =
      ({1'b0, accepts_first}  >= (CNT_W+1)'(first_size >> 1) + (CNT_W+1)'(1)) &&
      ({1'b0, accepts_second} >= (CNT_W+1)'(second_size >> 1) + (CNT_W+1)'(1));
    status.round_rejected =
      ({1'b0, rejects_first}  >= ((CNT_W+1)'(first_size) + (CNT_W+1)'(1)) >> 1) ||
      ({1'b0, rejects_second} >= ((CNT_W+1)'(second_size) + (CNT_W+1)'(1)) >> 1);
    status.round_complete =
      ((CNT_W+1)'(accepts_first) + (CNT_W+1)'(rejects_first) == (CNT_W+1)'(first_size)) &&
      ((CNT_W+1)'(accepts_second) + (CNT_W+1)'(rejects_second) == (CNT_W+1)'(second_size));
  end

  // Output register: load on leaving ST_DONE, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data <= status;
    end
  end

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> idx <= lim)
    else $error("slot walk ran past the group-one limit");

  a_accept_route: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> (state == ST_SEARCH || state == ST_UPDATE))
    else $error("accepted word did not start the sequencer");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && op == OP_CLEAR |=>
      (accepts_first == '0 && accepts_second == '0 &&
       rejects_first == '0 && rejects_second == '0))
    else $error("clear left a nonzero counter");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done state");

  a_no_hit_non_vote: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && (op == OP_LOAD || op == OP_CLEAR) |-> !hit)
    else $error("group-one hit flagged for a load or clear");
`endif

endmodule
